@@ rtl/ansi_sgr_color_parser_defines.svh @@
// Assertion macros for the ANSI SGR color parser checker.
`ifndef ANSI_SGR_COLOR_PARSER_DEFINES_SVH
`define ANSI_SGR_COLOR_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASGR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/asgr_pkg.sv @@
// Shared types, constants and the xterm-256 palette for the SGR color parser.
package asgr_pkg;

	localparam int MAX_PARAMS = 16;
	localparam int IDX_W      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
	localparam int PARAM_W    = 16;
	localparam int HELD_W     = 16;
	localparam int INK_W      = 24;

	localparam logic [INK_W-1:0] DEFAULT_INK_RESET = 24'hFFFFFF;

	// Byte codes
	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;

	// SGR codes
	localparam logic [PARAM_W-1:0] CODE_RESET   = 16'd0;
	localparam logic [PARAM_W-1:0] CODE_DEF_FG  = 16'd39;
	localparam logic [PARAM_W-1:0] CODE_FG_LO   = 16'd30;
	localparam logic [PARAM_W-1:0] CODE_FG_HI   = 16'd37;
	localparam logic [PARAM_W-1:0] CODE_BR_LO   = 16'd90;
	localparam logic [PARAM_W-1:0] CODE_BR_HI   = 16'd97;
	localparam logic [PARAM_W-1:0] CODE_EXT     = 16'd38;
	localparam logic [PARAM_W-1:0] SUB_INDEX    = 16'd5;
	localparam logic [PARAM_W-1:0] SUB_RGB      = 16'd2;

	// Palette index offsets: code 30 is entry 0, code 90 is entry 8
	localparam logic [7:0] PAL_FG_OFS = 8'd30;
	localparam logic [7:0] PAL_BR_OFS = 8'd82;

	localparam logic [7:0] LEVEL_DIM    = 8'd205;
	localparam logic [7:0] LEVEL_BRIGHT = 8'd255;
	localparam logic [7:0] PAL_CUBE_LO  = 8'd16;
	localparam logic [7:0] PAL_GREY_LO  = 8'd232;
	localparam logic [7:0] GREY_BASE    = 8'd8;

	typedef logic [CNT_W:0] asgr_wide_cnt_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_start;
		logic       text_end;
	} asgr_in_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              reoffer;
		logic [HELD_W-1:0] held_count;
		logic [7:0]        pen_red;
		logic [7:0]        pen_green;
		logic [7:0]        pen_blue;
	} asgr_res_t;

	typedef enum logic [1:0] {
		RES_PLAIN = 2'd0,
		RES_HELD  = 2'd1,
		RES_DONE  = 2'd2,
		RES_ABORT = 2'd3
	} asgr_status_t;

	typedef enum logic [3:0] {
		S_TEXT,
		S_ESC,
		S_PARAMS,
		S_W_CODE,
		S_W_SUB,
		S_W_IDX,
		S_W_RED,
		S_W_GREEN,
		S_W_BLUE,
		S_DONE
	} asgr_state_t;

	typedef enum logic [2:0] {
		PEN_HOLD,
		PEN_DEFAULT,
		PEN_FG,
		PEN_BRIGHT,
		PEN_INDEX,
		PEN_RGB
	} asgr_pen_sel_t;

	typedef enum logic [1:0] {
		HC_ZERO,
		HC_HELD,
		HC_HELD_INC
	} asgr_hc_sel_t;

	typedef struct packed {
		logic          seq_clear;
		logic          held_set;
		logic          held_inc;
		logic          acc_digit;
		logic          push;
		logic          walk_start;
		logic          walk;
		asgr_pen_sel_t pen_sel;
		logic          latch_r;
		logic          latch_g;
		logic          out_load;
		asgr_status_t  out_status;
		logic          out_reoffer;
		asgr_hc_sel_t  hc_sel;
	} asgr_cmd_t;

	typedef struct packed {
		logic start;
		logic last;
		logic is_esc;
		logic is_lbr;
		logic is_digit;
		logic is_semi;
		logic is_m;
		logic dv;
		logic walk_done;
		logic c_reset;
		logic c_fg;
		logic c_bright;
		logic c_ext;
		logic sub_index;
		logic sub_rgb;
		logic room_index;
		logic room_rgb;
	} asgr_stat_t;

	function automatic logic [7:0] cube_level(input logic [2:0] d);
		logic [7:0] lv;
		case (d)
			3'd0:    lv = 8'd0;
			3'd1:    lv = 8'd95;
			3'd2:    lv = 8'd135;
			3'd3:    lv = 8'd175;
			3'd4:    lv = 8'd215;
			default: lv = 8'd255;
		endcase
		return lv;
	endfunction

	// xterm-256 palette entry as 0xRRGGBB
	function automatic logic [INK_W-1:0] palette(input logic [7:0] n);
		logic [7:0] lv;
		logic [7:0] c;
		logic [7:0] rem;
		logic [7:0] gd;
		logic [7:0] gv;
		logic [2:0] dr;
		logic [2:0] dg;
		logic [2:0] db;
		logic [INK_W-1:0] rgb;
		lv  = n[3] ? LEVEL_BRIGHT : LEVEL_DIM;
		c   = n - PAL_CUBE_LO;
		dr  = 3'd0;
		dg  = 3'd0;
		for (int k = 1; k < 6; k++) begin
			if (c >= 8'(36 * k)) dr = 3'(k);
		end
		rem = c - 8'(36 * dr);
		for (int k = 1; k < 6; k++) begin
			if (rem >= 8'(6 * k)) dg = 3'(k);
		end
		db  = 3'(rem - 8'(6 * dg));
		gd  = n - PAL_GREY_LO;
		gv  = GREY_BASE + (gd << 3) + (gd << 1);
		if (n < PAL_CUBE_LO) begin
			rgb = {n[0] ? lv : 8'd0, n[1] ? lv : 8'd0, n[2] ? lv : 8'd0};
		end else if (n < PAL_GREY_LO) begin
			rgb = {cube_level(dr), cube_level(dg), cube_level(db)};
		end else begin
			rgb = {gv, gv, gv};
		end
		return rgb;
	endfunction

endpackage

@@ rtl/asgr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module asgr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/asgr_dp.sv @@
// Datapath: accumulator, parameter store, pen, palette and result register.
module asgr_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  asgr_pkg::asgr_cmd_t            cmd,
	input  asgr_pkg::asgr_in_t             byte_data,
	input  logic                           cfg_we,
	input  logic [asgr_pkg::INK_W-1:0]     cfg_data,
	output asgr_pkg::asgr_stat_t           stat,
	output asgr_pkg::asgr_res_t            res_data
);

	logic [asgr_pkg::INK_W-1:0]   default_q;
	logic [asgr_pkg::INK_W-1:0]   pen_q;
	logic [asgr_pkg::INK_W-1:0]   pen_d;
	logic [asgr_pkg::PARAM_W-1:0] acc_q;
	logic [asgr_pkg::CNT_W-1:0]   count_q;
	logic [asgr_pkg::HELD_W-1:0]  held_q;
	logic [asgr_pkg::HELD_W-1:0]  held_plus;
	logic [asgr_pkg::CNT_W-1:0]   rd_ptr_q;
	logic                         dv_s1;
	logic [asgr_pkg::IDX_W-1:0]   pos_s1;
	logic [7:0]                   red_q;
	logic [7:0]                   green_q;
	asgr_pkg::asgr_res_t          res_q;

	logic [19:0]                  acc_mul;
	logic [asgr_pkg::PARAM_W-1:0] acc_next;
	logic                         store_we;
	logic                         rd_issue;
	logic [asgr_pkg::PARAM_W-1:0] rd_data;
	logic [7:0]                   pal_idx;
	logic [asgr_pkg::HELD_W-1:0]  hc;
	asgr_pkg::asgr_wide_cnt_t     pos_w;
	asgr_pkg::asgr_wide_cnt_t     cnt_w;

	// Saturating decimal accumulate
	assign acc_mul  = {4'b0, acc_q} * 20'd10
		+ 20'(byte_data.text_byte[3:0] - asgr_pkg::CH_0[3:0]);
	assign acc_next = (acc_mul > 20'hFFFF) ? 16'hFFFF : acc_mul[15:0];

	assign held_plus = (held_q == '1) ? held_q : held_q + 16'd1;

	assign store_we = cmd.push && (count_q < asgr_pkg::CNT_W'(asgr_pkg::MAX_PARAMS));
	assign rd_issue = cmd.walk && (rd_ptr_q < count_q);

	asgr_ram #(
		.WIDTH(asgr_pkg::PARAM_W),
		.DEPTH(asgr_pkg::MAX_PARAMS)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(count_q[asgr_pkg::IDX_W-1:0]),
		.wdata(acc_q),
		.re   (rd_issue),
		.raddr(rd_ptr_q[asgr_pkg::IDX_W-1:0]),
		.rdata(rd_data)
	);

	assign pos_w = asgr_pkg::asgr_wide_cnt_t'(pos_s1);
	assign cnt_w = asgr_pkg::asgr_wide_cnt_t'(count_q);

	always_comb begin
		stat            = '0;
		stat.start      = byte_data.text_start;
		stat.last       = byte_data.text_end;
		stat.is_esc     = (byte_data.text_byte == asgr_pkg::CH_ESC);
		stat.is_lbr     = (byte_data.text_byte == asgr_pkg::CH_LBR);
		stat.is_digit   = byte_data.text_byte inside {[asgr_pkg::CH_0:asgr_pkg::CH_9]};
		stat.is_semi    = (byte_data.text_byte == asgr_pkg::CH_SEMI);
		stat.is_m       = (byte_data.text_byte == asgr_pkg::CH_M);
		stat.dv         = dv_s1;
		stat.walk_done  = !dv_s1 && (rd_ptr_q == count_q);
		stat.c_reset    = rd_data inside {asgr_pkg::CODE_RESET, asgr_pkg::CODE_DEF_FG};
		stat.c_fg       = rd_data inside {[asgr_pkg::CODE_FG_LO:asgr_pkg::CODE_FG_HI]};
		stat.c_bright   = rd_data inside {[asgr_pkg::CODE_BR_LO:asgr_pkg::CODE_BR_HI]};
		stat.c_ext      = (rd_data == asgr_pkg::CODE_EXT);
		stat.sub_index  = (rd_data == asgr_pkg::SUB_INDEX);
		stat.sub_rgb    = (rd_data == asgr_pkg::SUB_RGB);
		stat.room_index = (pos_w + asgr_pkg::asgr_wide_cnt_t'(1)) < cnt_w;
		stat.room_rgb   = (pos_w + asgr_pkg::asgr_wide_cnt_t'(3)) < cnt_w;
	end

	always_comb begin
		case (cmd.pen_sel)
			asgr_pkg::PEN_FG:     pal_idx = rd_data[7:0] - asgr_pkg::PAL_FG_OFS;
			asgr_pkg::PEN_BRIGHT: pal_idx = rd_data[7:0] - asgr_pkg::PAL_BR_OFS;
			default:              pal_idx = rd_data[7:0];
		endcase
	end

	always_comb begin
		case (cmd.pen_sel)
			asgr_pkg::PEN_HOLD:    pen_d = pen_q;
			asgr_pkg::PEN_DEFAULT: pen_d = default_q;
			asgr_pkg::PEN_FG,
			asgr_pkg::PEN_BRIGHT,
			asgr_pkg::PEN_INDEX:   pen_d = asgr_pkg::palette(pal_idx);
			asgr_pkg::PEN_RGB:     pen_d = {red_q, green_q, rd_data[7:0]};
			default:               pen_d = pen_q;
		endcase
	end

	always_comb begin
		case (cmd.hc_sel)
			asgr_pkg::HC_HELD:     hc = held_q;
			asgr_pkg::HC_HELD_INC: hc = held_plus;
			default:               hc = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= asgr_pkg::DEFAULT_INK_RESET;
			pen_q     <= asgr_pkg::DEFAULT_INK_RESET;
			acc_q     <= '0;
			count_q   <= '0;
			held_q    <= '0;
			rd_ptr_q  <= '0;
			dv_s1     <= 1'b0;
		end else begin
			if (cfg_we) default_q <= cfg_data;
			pen_q <= pen_d;

			if (cmd.seq_clear || cmd.push) begin
				acc_q <= '0;
			end else if (cmd.acc_digit) begin
				acc_q <= acc_next;
			end

			if (cmd.seq_clear) begin
				count_q <= '0;
			end else if (store_we) begin
				count_q <= count_q + asgr_pkg::CNT_W'(1);
			end

			if (cmd.held_set) begin
				held_q <= 16'd1;
			end else if (cmd.seq_clear) begin
				held_q <= '0;
			end else if (cmd.held_inc) begin
				held_q <= held_plus;
			end

			if (cmd.walk_start) begin
				rd_ptr_q <= '0;
			end else if (rd_issue) begin
				rd_ptr_q <= rd_ptr_q + asgr_pkg::CNT_W'(1);
			end
			dv_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) pos_s1 <= rd_ptr_q[asgr_pkg::IDX_W-1:0];
		if (cmd.latch_r) red_q <= rd_data[7:0];
		if (cmd.latch_g) green_q <= rd_data[7:0];
		if (cmd.out_load) begin
			res_q.status     <= cmd.out_status;
			res_q.reoffer    <= cmd.out_reoffer;
			res_q.held_count <= hc;
			res_q.pen_red    <= pen_d[23:16];
			res_q.pen_green  <= pen_d[15:8];
			res_q.pen_blue   <= pen_d[7:0];
		end
	end

	assign res_data = res_q;

endmodule

@@ rtl/asgr_ctrl.sv @@
// Controller: escape-sequence parse states, parameter walk and result handshake.
module asgr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	output logic                 res_valid,
	input  logic                 res_stall,
	input  asgr_pkg::asgr_stat_t stat,
	output asgr_pkg::asgr_cmd_t  cmd
);

	asgr_pkg::asgr_state_t   state_q;
	asgr_pkg::asgr_state_t   state_d;
	asgr_pkg::asgr_state_t   eff;
	asgr_pkg::asgr_pen_sel_t code_pen;
	logic                    res_valid_q;
	logic                    out_free;
	logic                    accept_state;
	logic                    accept;

	assign out_free     = !res_valid_q || !res_stall;
	assign accept_state = state_q inside {asgr_pkg::S_TEXT, asgr_pkg::S_ESC, asgr_pkg::S_PARAMS};
	assign byte_stall   = !(accept_state && out_free);
	assign accept       = byte_valid && !byte_stall;
	assign res_valid    = res_valid_q;

	// A text start drops any open sequence before the byte is parsed
	assign eff = stat.start ? asgr_pkg::S_TEXT : state_q;

	always_comb begin
		if (stat.c_reset) begin
			code_pen = asgr_pkg::PEN_DEFAULT;
		end else if (stat.c_fg) begin
			code_pen = asgr_pkg::PEN_FG;
		end else if (stat.c_bright) begin
			code_pen = asgr_pkg::PEN_BRIGHT;
		end else begin
			code_pen = asgr_pkg::PEN_HOLD;
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.pen_sel    = asgr_pkg::PEN_HOLD;
		cmd.out_status = asgr_pkg::RES_PLAIN;
		cmd.hc_sel     = asgr_pkg::HC_ZERO;
		state_d        = state_q;

		case (state_q)
			asgr_pkg::S_TEXT, asgr_pkg::S_ESC, asgr_pkg::S_PARAMS: begin
				if (accept) begin
					cmd.out_load = 1'b1;
					if (stat.start) begin
						cmd.seq_clear = 1'b1;
						cmd.pen_sel   = asgr_pkg::PEN_DEFAULT;
					end
					case (eff)
						asgr_pkg::S_ESC: begin
							if (stat.is_lbr && stat.last) begin
								cmd.out_status = asgr_pkg::RES_ABORT;
								cmd.hc_sel     = asgr_pkg::HC_HELD_INC;
								cmd.seq_clear  = 1'b1;
								state_d        = asgr_pkg::S_TEXT;
							end else if (stat.is_lbr) begin
								cmd.held_inc   = 1'b1;
								cmd.out_status = asgr_pkg::RES_HELD;
								state_d        = asgr_pkg::S_PARAMS;
							end else begin
								cmd.out_status  = asgr_pkg::RES_ABORT;
								cmd.out_reoffer = 1'b1;
								cmd.hc_sel      = asgr_pkg::HC_HELD;
								cmd.seq_clear   = 1'b1;
								state_d         = asgr_pkg::S_TEXT;
							end
						end
						asgr_pkg::S_PARAMS: begin
							if ((stat.is_digit || stat.is_semi) && stat.last) begin
								cmd.out_status = asgr_pkg::RES_ABORT;
								cmd.hc_sel     = asgr_pkg::HC_HELD_INC;
								cmd.seq_clear  = 1'b1;
								state_d        = asgr_pkg::S_TEXT;
							end else if (stat.is_digit || stat.is_semi) begin
								cmd.acc_digit  = stat.is_digit;
								cmd.push       = stat.is_semi;
								cmd.held_inc   = 1'b1;
								cmd.out_status = asgr_pkg::RES_HELD;
							end else if (stat.is_m) begin
								// Store the final field, then walk the list
								cmd.out_load   = 1'b0;
								cmd.push       = 1'b1;
								cmd.walk_start = 1'b1;
								state_d        = asgr_pkg::S_W_CODE;
							end else begin
								cmd.out_status  = asgr_pkg::RES_ABORT;
								cmd.out_reoffer = 1'b1;
								cmd.hc_sel      = asgr_pkg::HC_HELD;
								cmd.seq_clear   = 1'b1;
								state_d         = asgr_pkg::S_TEXT;
							end
						end
						default: begin
							if (stat.is_esc && !stat.last) begin
								cmd.seq_clear  = 1'b1;
								cmd.held_set   = 1'b1;
								cmd.out_status = asgr_pkg::RES_HELD;
								state_d        = asgr_pkg::S_ESC;
							end else begin
								state_d = asgr_pkg::S_TEXT;
							end
						end
					endcase
				end
			end
			asgr_pkg::S_W_CODE, asgr_pkg::S_W_SUB, asgr_pkg::S_W_IDX,
			asgr_pkg::S_W_RED, asgr_pkg::S_W_GREEN, asgr_pkg::S_W_BLUE: begin
				cmd.walk = 1'b1;
				if (stat.walk_done) begin
					state_d = asgr_pkg::S_DONE;
				end else if (stat.dv) begin
					case (state_q)
						asgr_pkg::S_W_SUB: begin
							if (stat.sub_index && stat.room_index) begin
								state_d = asgr_pkg::S_W_IDX;
							end else if (stat.sub_rgb && stat.room_rgb) begin
								state_d = asgr_pkg::S_W_RED;
							end else begin
								// Lone 38: take this entry as a fresh code
								cmd.pen_sel = code_pen;
								state_d = stat.c_ext ? asgr_pkg::S_W_SUB : asgr_pkg::S_W_CODE;
							end
						end
						asgr_pkg::S_W_IDX: begin
							cmd.pen_sel = asgr_pkg::PEN_INDEX;
							state_d     = asgr_pkg::S_W_CODE;
						end
						asgr_pkg::S_W_RED: begin
							cmd.latch_r = 1'b1;
							state_d     = asgr_pkg::S_W_GREEN;
						end
						asgr_pkg::S_W_GREEN: begin
							cmd.latch_g = 1'b1;
							state_d     = asgr_pkg::S_W_BLUE;
						end
						asgr_pkg::S_W_BLUE: begin
							cmd.pen_sel = asgr_pkg::PEN_RGB;
							state_d     = asgr_pkg::S_W_CODE;
						end
						default: begin
							cmd.pen_sel = code_pen;
							state_d = stat.c_ext ? asgr_pkg::S_W_SUB : asgr_pkg::S_W_CODE;
						end
					endcase
				end
			end
			asgr_pkg::S_DONE: begin
				if (out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = asgr_pkg::RES_DONE;
					cmd.seq_clear  = 1'b1;
					state_d        = asgr_pkg::S_TEXT;
				end
			end
			default: begin
				state_d = asgr_pkg::S_TEXT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= asgr_pkg::S_TEXT;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/ansi_sgr_color_parser.sv @@
// Top level of the ANSI SGR pen color parser.
// Takes one text byte per input word and returns one result word per byte: the
// byte's parse status (plain, held in an escape sequence, sequence done, or
// sequence aborted with the held byte count and a reoffer flag) and the pen
// color after that byte. Sequences are ESC '[' params 'm', with params split by
// ';'; up to 16 params are stored in a small RAM and later ones are dropped.
// The result is held in a single registered word, so the next byte is taken
// no earlier than the cycle in which the previous result word leaves, and a
// stalled result stalls the byte input. The terminating 'm' reads the parameter
// RAM one entry per cycle through its one read port, with registered read
// data, and posts the result once the result output is free. A byte marked as
// the start of a text resets the pen to the default ink first. The user must
// write the default ink register through the cfg channel only while no byte is
// in flight; the block itself does not enforce this. A new value takes effect
// the next time the pen is reset to default.
module ansi_sgr_color_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       byte_valid,
	output logic                       byte_stall,
	input  asgr_pkg::asgr_in_t         byte_data,
	output logic                       res_valid,
	input  logic                       res_stall,
	output asgr_pkg::asgr_res_t        res_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [asgr_pkg::INK_W-1:0] cfg_data
);

	asgr_pkg::asgr_cmd_t  cmd;
	asgr_pkg::asgr_stat_t stat;

	// The ink register is a plain flop; take a write word on any cycle
	assign cfg_ready = 1'b1;

	asgr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	asgr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.byte_data(byte_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.stat     (stat),
		.res_data (res_data)
	);

endmodule

@@ rtl/asgr_checker.sv @@
// Port-level checker for the SGR color parser, bound to the top level.
`include "ansi_sgr_color_parser_defines.svh"

module asgr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                byte_valid,
	input logic                byte_stall,
	input asgr_pkg::asgr_in_t  byte_data,
	input logic                res_valid,
	input logic                res_stall,
	input asgr_pkg::asgr_res_t res_data
);

	`ASGR_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res_data), "result word changed while stalled")
	`ASGR_ASSERT_NEXT(a_byte_result, clk, arst_n, byte_valid && !byte_stall && byte_data.text_byte != asgr_pkg::CH_M, res_valid, "accepted byte gave no result word")
	`ASGR_ASSERT_NOW(a_reoffer_abort, clk, arst_n, res_valid && res_data.reoffer, res_data.status == asgr_pkg::RES_ABORT, "reoffer outside an abort")
	`ASGR_ASSERT_NOW(a_count_abort, clk, arst_n, res_valid && res_data.status != asgr_pkg::RES_ABORT, res_data.held_count == '0, "held count outside an abort")

endmodule

bind ansi_sgr_color_parser asgr_checker u_asgr_checker (.*);
